// File: hdl/pfrp_pkg.sv
// Shared types and codes for the paced FIFO read port.
package pfrp_pkg;

   // Item kinds on the request channel
   typedef enum logic [1:0] {
      MODE_PIN   = 2'd0,
      MODE_PUSH  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_TICK  = 2'd3
   } mode_type;

   // Control register indexes
   localparam logic CSR_READY_MODE = 1'b0;
   localparam logic CSR_PACE_TICKS = 1'b1;

   localparam logic [7:0] PACE_TICKS_RESET = 8'd4;

   // Ring commands, at most one set per item
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } ring_cmd_type;

   // Ring status: empty/full/head before the command, level after it
   typedef struct packed {
      logic       empty;
      logic       full;
      logic [7:0] head;
      logic [7:0] level;
   } ring_stat_type;

   // Port state after one item
   typedef struct packed {
      logic        offered;
      logic        hold_active;
      logic [7:0]  offered_byte;
      logic [7:0]  captured_bus;
      logic [31:0] read_total;
      logic [31:0] drop_total;
      logic        dropped;
   } ctrl_out_type;

endpackage

// File: hdl/pfrp_ring.sv
// Byte ring with registered-read memory and a head-of-queue bypass.
module pfrp_ring #(
   parameter int DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pfrp_pkg::ring_cmd_type cmd,
   input  logic [7:0]             wr_data,
   output pfrp_pkg::ring_stat_type stat
);

   localparam int AW = $clog2(DEPTH);

   logic [7:0]    mem [DEPTH];
   logic [AW-1:0] write_ptr_ff, write_ptr_in;
   logic [AW-1:0] read_ptr_ff, read_ptr_in;
   logic [AW-1:0] count_ff, count_in;
   logic [AW-1:0] write_nx, read_nx;
   logic [7:0]    mem_q_ff;
   logic          byp_ff, byp_in;
   logic [7:0]    byp_data_ff;
   logic          push_ok, pop_ok;
   logic [AW+7:0] count_ext;

   // Pointer wrap at DEPTH
   assign write_nx = (write_ptr_ff == AW'(DEPTH - 1)) ? '0 : write_ptr_ff + AW'(1);
   assign read_nx  = (read_ptr_ff == AW'(DEPTH - 1)) ? '0 : read_ptr_ff + AW'(1);

   assign stat.empty = (write_ptr_ff == read_ptr_ff);
   assign stat.full  = (write_nx == read_ptr_ff);
   assign stat.head  = byp_ff ? byp_data_ff : mem_q_ff;

   assign push_ok = cmd.push && !stat.full;
   assign pop_ok  = cmd.pop && !stat.empty;

   // Next pointers and fill count
   always_comb begin
      write_ptr_in = write_ptr_ff;
      read_ptr_in  = read_ptr_ff;
      count_in     = count_ff;
      if (cmd.clear) begin
         write_ptr_in = '0;
         read_ptr_in  = '0;
         count_in     = '0;
      end else if (push_ok) begin
         write_ptr_in = write_nx;
         count_in     = count_ff + AW'(1);
      end else if (pop_ok) begin
         read_ptr_in = read_nx;
         count_in    = count_ff - AW'(1);
      end
   end

   // Level after the command, saturated to a byte
   assign count_ext  = {8'd0, count_in};
   assign stat.level = (count_ext > (AW+8)'(255)) ? 8'hFF : count_ext[7:0];

   // A write to the slot that becomes the head is forwarded for one cycle
   assign byp_in = push_ok && (write_ptr_ff == read_ptr_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff <= '0;
         read_ptr_ff  <= '0;
         count_ff     <= '0;
         byp_ff       <= 1'b0;
      end else begin
         write_ptr_ff <= write_ptr_in;
         read_ptr_ff  <= read_ptr_in;
         count_ff     <= count_in;
         byp_ff       <= byp_in;
      end
   end

   // Storage: one write port, one registered read at the next head
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[write_ptr_ff] <= wr_data;
      end
      mem_q_ff    <= mem[read_ptr_in];
      byp_data_ff <= wr_data;
   end

endmodule

// File: hdl/pfrp_ctrl.sv
// Offer, strobe edge and pacing logic of the read port.
module pfrp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic [1:0]              mode,
   input  logic [7:0]              push_byte,
   input  logic                    rd_level,
   input  logic [7:0]              bus_value,
   input  logic [7:0]              pace_ticks,
   input  pfrp_pkg::ring_stat_type stat,
   output pfrp_pkg::ring_cmd_type  cmd,
   output pfrp_pkg::ctrl_out_type  res
);

   logic        prev_strobe_ff, prev_strobe_in;
   logic        offered_ff;
   logic        hold_active_ff;
   logic [7:0]  hold_left_ff, hold_left_in;
   logic [7:0]  offered_byte_ff;
   logic [7:0]  captured_bus_ff;
   logic [31:0] read_total_ff;
   logic [31:0] drop_total_ff;

   pfrp_pkg::ring_cmd_type cmd_raw;

   // One item: action, presentation check, strobe edges
   always_comb begin
      logic       have;
      logic [7:0] hd;
      have           = !stat.empty;
      hd             = stat.head;
      cmd_raw        = '0;
      res.offered      = offered_ff;
      res.hold_active  = hold_active_ff;
      res.offered_byte = offered_byte_ff;
      res.captured_bus = captured_bus_ff;
      res.read_total   = read_total_ff;
      res.drop_total   = drop_total_ff;
      res.dropped      = 1'b0;
      hold_left_in     = hold_left_ff;
      prev_strobe_in   = prev_strobe_ff;

      case (pfrp_pkg::mode_type'(mode))
         pfrp_pkg::MODE_PIN: begin
         end
         pfrp_pkg::MODE_PUSH: begin
            cmd_raw.push = 1'b1;
            if (stat.full) begin
               res.drop_total = drop_total_ff + 32'd1;
               res.dropped    = 1'b1;
            end else if (!have) begin
               have = 1'b1;
               hd   = push_byte;
            end
         end
         pfrp_pkg::MODE_CLEAR: begin
            cmd_raw.clear   = 1'b1;
            have            = 1'b0;
            res.offered     = 1'b0;
            res.hold_active = 1'b0;
         end
         pfrp_pkg::MODE_TICK: begin
            if (hold_active_ff && (hold_left_ff != 8'd0)) begin
               hold_left_in = hold_left_ff - 8'd1;
            end
         end
         default: begin
         end
      endcase

      // Presentation: offer the head once any hold has run out
      if (!res.offered && !(res.hold_active && (hold_left_in != 8'd0))) begin
         res.hold_active = 1'b0;
         if (have) begin
            res.offered      = 1'b1;
            res.offered_byte = hd;
         end
      end

      // RD# edges: falling captures the bus, rising completes the read
      if (pfrp_pkg::mode_type'(mode) == pfrp_pkg::MODE_PIN) begin
         if (prev_strobe_ff && !rd_level) begin
            res.captured_bus = bus_value;
         end else if (!prev_strobe_ff && rd_level) begin
            if (res.offered) begin
               cmd_raw.pop    = 1'b1;
               res.read_total = read_total_ff + 32'd1;
            end
            res.offered     = 1'b0;
            res.hold_active = 1'b1;
            hold_left_in    = pace_ticks;
         end
         prev_strobe_in = rd_level;
      end
   end

   assign cmd = fire ? cmd_raw : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_strobe_ff  <= 1'b1;
         offered_ff      <= 1'b0;
         hold_active_ff  <= 1'b0;
         hold_left_ff    <= 8'd0;
         offered_byte_ff <= 8'd0;
         captured_bus_ff <= 8'd0;
         read_total_ff   <= 32'd0;
         drop_total_ff   <= 32'd0;
      end else if (fire) begin
         prev_strobe_ff  <= prev_strobe_in;
         offered_ff      <= res.offered;
         hold_active_ff  <= res.hold_active;
         hold_left_ff    <= hold_left_in;
         offered_byte_ff <= res.offered_byte;
         captured_bus_ff <= res.captured_bus;
         read_total_ff   <= res.read_total;
         drop_total_ff   <= res.drop_total;
      end
   end

endmodule

// File: hdl/paced_fifo_read_port_core.sv
// Paced FIFO read port: request register, port logic, ring and result register.
// One request is taken every clock while the result side does not stall; its
// result is offered from the result register: the request register feeds the
// port logic, which updates the state and loads the result register together.
// The ring is a single-write, single-read memory whose read data is registered
// at the next head position; a byte written into an empty ring is forwarded,
// so a back-to-back push and pin sample sees it at once. No clearing pass
// follows reset. The result register does not part the two channels: a stall
// on a full result register holds the request register and reaches req_stall
// in the same cycle.
module paced_fifo_read_port_core #(
   parameter int DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_push_byte,
   input  logic        req_rd_level,
   input  logic [7:0]  req_bus_value,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_rxf_n,
   output logic        rsp_txe_n,
   output logic        rsp_drive_enable,
   output logic [7:0]  rsp_drive_data,
   output logic [7:0]  rsp_queue_level,
   output logic        rsp_push_dropped,
   output logic        rsp_pacing,
   output logic [7:0]  rsp_last_read_bus,
   output logic [31:0] rsp_bytes_read,
   output logic [31:0] rsp_overflow_count,
   // control register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   logic       s1_valid_ff;
   logic [1:0] s1_mode_ff;
   logic [7:0] s1_push_byte_ff;
   logic       s1_rd_level_ff;
   logic [7:0] s1_bus_value_ff;
   logic       fire;
   logic       out_valid_ff;
   logic       ready_mode_ff;
   logic [7:0] pace_ticks_ff;
   logic [7:0] level_ff;
   logic       txe_n_ff;

   pfrp_pkg::ring_cmd_type  ring_cmd;
   pfrp_pkg::ring_stat_type ring_stat;
   pfrp_pkg::ctrl_out_type  ctrl_res;
   pfrp_pkg::ctrl_out_type  out_ff;

   // Handshake: process when the result register is free or emptying
   assign fire      = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !fire;

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_mode_ff      <= req_mode;
         s1_push_byte_ff <= req_push_byte;
         s1_rd_level_ff  <= req_rd_level;
         s1_bus_value_ff <= req_bus_value;
      end
   end

   // Control registers, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_mode_ff <= 1'b0;
         pace_ticks_ff <= pfrp_pkg::PACE_TICKS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            pfrp_pkg::CSR_READY_MODE: ready_mode_ff <= csr_data[0];
            pfrp_pkg::CSR_PACE_TICKS: pace_ticks_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   pfrp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .mode       (s1_mode_ff),
      .push_byte  (s1_push_byte_ff),
      .rd_level   (s1_rd_level_ff),
      .bus_value  (s1_bus_value_ff),
      .pace_ticks (pace_ticks_ff),
      .stat       (ring_stat),
      .cmd        (ring_cmd),
      .res        (ctrl_res)
   );

   pfrp_ring #(
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ring_cmd),
      .wr_data (s1_push_byte_ff),
      .stat    (ring_stat)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff   <= ctrl_res;
         level_ff <= ring_stat.level;
         txe_n_ff <= !ready_mode_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_rxf_n          = !out_ff.offered;
   assign rsp_txe_n          = txe_n_ff;
   assign rsp_drive_enable   = out_ff.offered;
   assign rsp_drive_data     = out_ff.offered ? out_ff.offered_byte : 8'd0;
   assign rsp_queue_level    = level_ff;
   assign rsp_push_dropped   = out_ff.dropped;
   assign rsp_pacing         = out_ff.hold_active;
   assign rsp_last_read_bus  = out_ff.captured_bus;
   assign rsp_bytes_read     = out_ff.read_total;
   assign rsp_overflow_count = out_ff.drop_total;

`ifndef ASSERT_OFF
   // Ring can never report full and empty together
   a_ring_full_empty: assert property (@(posedge clock) disable iff (reset)
      !(ring_stat.full && ring_stat.empty))
      else $error("ring reports full and empty together");

   // A read only pops a ring that holds a byte
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ring_cmd.pop |-> !ring_stat.empty)
      else $error("pop issued on an empty ring");

   // Only one ring command per item
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ring_cmd.push, ring_cmd.pop, ring_cmd.clear}))
      else $error("more than one ring command at once");

   // A request transfer is always held in the request register next cycle
   a_req_taken: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted request lost");
`endif

endmodule
